// ----- rtl/csd_pkg.sv -----
package csd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_TRAILER
  } phase_t;

  localparam int HdrBytes    = 52;
  localparam int HdrCrcSpan  = 48;
  localparam int HdrStoreLen = HdrBytes - 1;

  localparam logic [5:0] HdrPosMagicEnd = 6'd3;
  localparam logic [5:0] HdrPosCrcSpan  = 6'(HdrCrcSpan);
  localparam logic [5:0] HdrPosLast     = 6'(HdrBytes - 1);

  localparam logic [7:0] MAGIC_0 = 8'h53;  // 'S'
  localparam logic [7:0] MAGIC_1 = 8'h46;  // 'F'
  localparam logic [7:0] MAGIC_2 = 8'h46;  // 'F'
  localparam logic [7:0] MAGIC_3 = 8'h31;  // '1'

  localparam logic        CMD_BYTE  = 1'b0;
  localparam logic        CMD_CLEAR = 1'b1;

  localparam logic        KIND_PAYLOAD = 1'b0;
  localparam logic        KIND_REPORT  = 1'b1;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_MAGIC       = 3'd1;
  localparam logic [2:0] ST_HDR_CRC     = 3'd2;
  localparam logic [2:0] ST_VERSION     = 3'd3;
  localparam logic [2:0] ST_TYPE        = 3'd4;
  localparam logic [2:0] ST_LENGTH      = 3'd5;
  localparam logic [2:0] ST_PAYLOAD_CRC = 3'd6;

  localparam logic [1:0] CFG_PAYLOAD_CAP      = 2'd0;
  localparam logic [1:0] CFG_EXPECTED_VERSION = 2'd1;
  localparam logic [1:0] CFG_LOWEST_TYPE      = 2'd2;
  localparam logic [1:0] CFG_HIGHEST_TYPE     = 2'd3;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Reflected CRC-32, one byte per call.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- rtl/crc_checked_stream_deframer.sv -----
// An accepted byte waits in the input register while a stalled result holds the output.
// Throughput: one byte per cycle when no result stalls; the byte-wide CRC-32 update and
// the header checks sit in the single logic stage between input and result registers.
// Results leave through a result register, so a new byte is taken while one waits.
// Synchronous active-high reset clears the frame position, CRCs, halt flag and the
// configuration registers to their defaults; the header bytes are not cleared.
module crc_checked_stream_deframer #(
  parameter int HARD_MAX_PAYLOAD = 65536
) (
  input  logic        clk,
  input  logic        rst,

  input  logic        feed_valid,
  output logic        feed_stall,
  input  logic        cmd,
  input  logic [7:0]  byte_value,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,

  output logic        res_valid,
  input  logic        res_stall,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [2:0]  status,
  output logic [15:0] msg_type,
  output logic [31:0] frame_flags,
  output logic [63:0] session_word,
  output logic [63:0] epoch_word,
  output logic [63:0] boot_word,
  output logic [63:0] sequence_word,
  output logic [16:0] payload_length,
  output logic        last
);
  import csd_pkg::*;

  localparam logic [31:0] HardMax = 32'(HARD_MAX_PAYLOAD);

  // Configuration registers.
  logic [16:0] payload_cap;
  logic [15:0] expected_version;
  logic [15:0] lowest_type;
  logic [15:0] highest_type;

  // Input register.
  logic        q_valid;
  logic        q_cmd;
  logic [7:0]  q_byte;

  // Frame state.
  phase_t      phase, phase_next;
  logic [5:0]  hdr_pos, hdr_pos_next;
  logic [16:0] remaining, remaining_next;
  logic [1:0]  trailer_idx, trailer_idx_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] trailer_crc, trailer_crc_next;
  logic        halted, halted_next;
  logic [7:0]  hdr [HdrStoreLen];
  logic        hdr_write;

  // Header fields as stored.
  logic [15:0] hdr_version;
  logic [15:0] hdr_type;
  logic [31:0] hdr_flags;
  logic [63:0] hdr_session;
  logic [63:0] hdr_epoch;
  logic [63:0] hdr_boot;
  logic [63:0] hdr_sequence;
  logic [31:0] hdr_len;
  logic [31:0] hdr_crc;
  logic [31:0] ceiling;
  logic        len_ok;

  logic        go;
  logic        accept;
  logic        emit;
  logic        emit_kind;
  logic        emit_header;
  logic [2:0]  emit_status;

  assign cfg_ready  = 1'b1;
  assign accept     = feed_valid && !feed_stall;
  assign go         = q_valid && (!res_valid || !res_stall);
  assign feed_stall = q_valid && !go;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_cap      <= 17'd65536;
      expected_version <= 16'd1;
      lowest_type      <= 16'd1;
      highest_type     <= 16'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PAYLOAD_CAP:      payload_cap      <= cfg_data;
        CFG_EXPECTED_VERSION: expected_version <= cfg_data[15:0];
        CFG_LOWEST_TYPE:      lowest_type      <= cfg_data[15:0];
        CFG_HIGHEST_TYPE:     highest_type     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (go) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_cmd  <= cmd;
      q_byte <= byte_value;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      hdr_version[8*i +: 8] = hdr[4 + i];
      hdr_type[8*i +: 8]    = hdr[6 + i];
    end
    for (int i = 0; i < 4; i++) begin
      hdr_flags[8*i +: 8] = hdr[8 + i];
      hdr_len[8*i +: 8]   = hdr[44 + i];
    end
    for (int i = 0; i < 8; i++) begin
      hdr_session[8*i +: 8]  = hdr[12 + i];
      hdr_epoch[8*i +: 8]    = hdr[20 + i];
      hdr_boot[8*i +: 8]     = hdr[28 + i];
      hdr_sequence[8*i +: 8] = hdr[36 + i];
    end
    // The last header byte is still in the input register when the check runs.
    hdr_crc = {q_byte, hdr[50], hdr[49], hdr[48]};
  end

  assign ceiling = ({15'd0, payload_cap} < HardMax) ? {15'd0, payload_cap} : HardMax;
  assign len_ok  = hdr_len <= ceiling;

  always_comb begin
    phase_next       = phase;
    hdr_pos_next     = hdr_pos;
    remaining_next   = remaining;
    trailer_idx_next = trailer_idx;
    running_crc_next = running_crc;
    trailer_crc_next = trailer_crc;
    halted_next      = halted;
    hdr_write        = 1'b0;
    emit             = 1'b0;
    emit_kind        = KIND_REPORT;
    emit_header      = 1'b0;
    emit_status      = ST_OK;

    if (q_cmd == CMD_CLEAR) begin
      phase_next       = PH_HEADER;
      hdr_pos_next     = '0;
      trailer_idx_next = '0;
      running_crc_next = CRC_INIT;
      trailer_crc_next = '0;
      halted_next      = 1'b0;
    end else if (!halted) begin
      case (phase)
        PH_HEADER: begin
          hdr_write    = hdr_pos != HdrPosLast;
          hdr_pos_next = hdr_pos + 6'd1;
          if (hdr_pos < HdrPosCrcSpan) begin
            running_crc_next = crc32_byte(running_crc, q_byte);
          end
          if (hdr_pos == HdrPosMagicEnd) begin
            if (hdr[0] != MAGIC_0 || hdr[1] != MAGIC_1 || hdr[2] != MAGIC_2 ||
                q_byte != MAGIC_3) begin
              emit        = 1'b1;
              emit_status = ST_MAGIC;
              halted_next = 1'b1;
            end
          end else if (hdr_pos == HdrPosLast) begin
            hdr_pos_next = '0;
            emit_header  = 1'b1;
            if (hdr_crc != ~running_crc) begin
              emit_status = ST_HDR_CRC;
            end else if (hdr_version != expected_version) begin
              emit_status = ST_VERSION;
            end else if (hdr_type < lowest_type || hdr_type > highest_type) begin
              emit_status = ST_TYPE;
            end else if (!len_ok) begin
              emit_status = ST_LENGTH;
            end
            if (emit_status != ST_OK) begin
              emit        = 1'b1;
              halted_next = 1'b1;
            end else begin
              running_crc_next = CRC_INIT;
              trailer_crc_next = '0;
              trailer_idx_next = '0;
              remaining_next   = hdr_len[16:0];
              phase_next       = (hdr_len == 32'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          running_crc_next = crc32_byte(running_crc, q_byte);
          remaining_next   = remaining - 17'd1;
          emit             = 1'b1;
          emit_kind        = KIND_PAYLOAD;
          if (remaining == 17'd1) begin
            phase_next = PH_TRAILER;
          end
        end
        PH_TRAILER: begin
          // Little-endian trailer: bytes shift in from the top.
          trailer_crc_next = {q_byte, trailer_crc[31:8]};
          trailer_idx_next = trailer_idx + 2'd1;
          if (trailer_idx == 2'd3) begin
            emit        = 1'b1;
            emit_header = 1'b1;
            if (trailer_crc_next != ~running_crc) begin
              emit_status = ST_PAYLOAD_CRC;
              halted_next = 1'b1;
            end else begin
              phase_next       = PH_HEADER;
              hdr_pos_next     = '0;
              running_crc_next = CRC_INIT;
              trailer_crc_next = '0;
            end
          end
        end
        default: begin
          phase_next = PH_HEADER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      hdr_pos     <= '0;
      remaining   <= '0;
      trailer_idx <= '0;
      running_crc <= CRC_INIT;
      trailer_crc <= '0;
      halted      <= 1'b0;
    end else if (go) begin
      phase       <= phase_next;
      hdr_pos     <= hdr_pos_next;
      remaining   <= remaining_next;
      trailer_idx <= trailer_idx_next;
      running_crc <= running_crc_next;
      trailer_crc <= trailer_crc_next;
      halted      <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && hdr_write) begin
      hdr[hdr_pos] <= q_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (go) begin
      res_valid <= emit;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && emit) begin
      kind           <= emit_kind;
      last           <= emit_kind == KIND_REPORT;
      payload_byte   <= (emit_kind == KIND_PAYLOAD) ? q_byte : 8'd0;
      status         <= emit_status;
      msg_type       <= emit_header ? hdr_type : 16'd0;
      frame_flags    <= emit_header ? hdr_flags : 32'd0;
      session_word   <= emit_header ? hdr_session : 64'd0;
      epoch_word     <= emit_header ? hdr_epoch : 64'd0;
      boot_word      <= emit_header ? hdr_boot : 64'd0;
      sequence_word  <= emit_header ? hdr_sequence : 64'd0;
      payload_length <= (emit_header && len_ok) ? hdr_len[16:0] : 17'd0;
    end
  end

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == KIND_PAYLOAD |-> !last && status == ST_OK)
    else $error("payload item carries report fields");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    go && emit && emit_status != ST_OK |=> halted)
    else $error("error report did not halt the stream");

  a_payload_count: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> remaining != 17'd0)
    else $error("payload phase with nothing left to take");

  a_hdr_pos_range: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER |-> hdr_pos <= HdrPosLast)
    else $error("header position past the header");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    feed_stall |-> q_valid && res_valid && res_stall)
    else $error("input stalled without a full pipeline");

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  import csd_pkg::*;

  localparam int unsigned PayloadCeiling = 65536;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic [15:0] msg_type;
    logic [31:0] frame_flags;
    logic [63:0] session_word;
    logic [63:0] epoch_word;
    logic [63:0] boot_word;
    logic [63:0] sequence_word;
    logic [16:0] payload_length;
    logic        last;
  } deframe_result_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_HDR_CRC,
    FLAW_TRAILER,
    FLAW_CUT
  } frame_flaw_t;

  class deframe_predictor;
    logic [16:0] payload_cap_reg;
    logic [15:0] version_reg;
    logic [15:0] type_lo_reg;
    logic [15:0] type_hi_reg;

    int unsigned position;
    logic [7:0]  hdr [HdrBytes];
    logic [31:0] crc_acc;
    logic [31:0] trailer_acc;
    bit          halted;
    logic [31:0] crc_table [256];

    deframe_result_t awaited [$];
    int errors;

    function new();
      logic [31:0] c;
      for (int n = 0; n < 256; n++) begin
        c = 32'(n);
        repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        crc_table[n] = c;
      end
      payload_cap_reg = 17'd65536;
      version_reg = 16'd1;
      type_lo_reg = 16'd1;
      type_hi_reg = 16'd16;
      halted = 1'b0;
      errors = 0;
      restart();
    endfunction

    function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      return crc_table[c[7:0] ^ b] ^ (c >> 8);
    endfunction

    function int unsigned bound();
      return (payload_cap_reg < PayloadCeiling) ? payload_cap_reg : PayloadCeiling;
    endfunction

    function void restart();
      position = 0;
      crc_acc = CRC_INIT;
      trailer_acc = '0;
    endfunction

    function logic [63:0] hdr_field(int off, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v[8*i +: 8] = hdr[off + i];
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] val);
      case (idx)
        CFG_PAYLOAD_CAP:      payload_cap_reg = val;
        CFG_EXPECTED_VERSION: version_reg = val[15:0];
        CFG_LOWEST_TYPE:      type_lo_reg = val[15:0];
        CFG_HIGHEST_TYPE:     type_hi_reg = val[15:0];
        default: ;
      endcase
    endfunction

    function void push_report(logic [2:0] st, bit with_hdr);
      deframe_result_t r;
      logic [31:0] len32;
      r = '0;
      r.kind = KIND_REPORT;
      r.status = st;
      r.last = 1'b1;
      if (with_hdr) begin
        len32 = 32'(hdr_field(44, 4));
        r.msg_type = 16'(hdr_field(6, 2));
        r.frame_flags = 32'(hdr_field(8, 4));
        r.session_word = hdr_field(12, 8);
        r.epoch_word = hdr_field(20, 8);
        r.boot_word = hdr_field(28, 8);
        r.sequence_word = hdr_field(36, 8);
        // The length is only reported once it is known to fit the bound.
        if (st != ST_LENGTH && len32 <= bound()) r.payload_length = len32[16:0];
      end
      awaited.push_back(r);
    endfunction

    function void fail(logic [2:0] st, bit with_hdr);
      halted = 1'b1;
      push_report(st, with_hdr);
    endfunction

    function void predict_item(logic c, logic [7:0] b);
      int unsigned p;
      int unsigned len;
      int unsigned k;
      logic [31:0] stored_crc;
      logic [31:0] len32;
      logic [15:0] ver;
      logic [15:0] typ;
      deframe_result_t r;
      if (c == CMD_CLEAR) begin
        restart();
        halted = 1'b0;
        return;
      end
      if (halted) return;
      p = position;
      if (p < HdrBytes) begin
        hdr[p] = b;
        if (p < HdrCrcSpan) crc_acc = crc_next(crc_acc, b);
        position = p + 1;
        if (p == HdrPosMagicEnd) begin
          if (hdr[0] != MAGIC_0 || hdr[1] != MAGIC_1 || hdr[2] != MAGIC_2 ||
              hdr[3] != MAGIC_3) fail(ST_MAGIC, 1'b0);
        end else if (p == HdrBytes - 1) begin
          stored_crc = 32'(hdr_field(48, 4));
          ver = 16'(hdr_field(4, 2));
          typ = 16'(hdr_field(6, 2));
          len32 = 32'(hdr_field(44, 4));
          if (stored_crc != (crc_acc ^ CRC_INIT)) fail(ST_HDR_CRC, 1'b1);
          else if (ver != version_reg) fail(ST_VERSION, 1'b1);
          else if (typ < type_lo_reg || typ > type_hi_reg) fail(ST_TYPE, 1'b1);
          else if (len32 > bound()) fail(ST_LENGTH, 1'b1);
          else begin
            crc_acc = CRC_INIT;
            trailer_acc = '0;
          end
        end
        return;
      end
      len = 32'(hdr_field(44, 4));
      if (p < HdrBytes + len) begin
        crc_acc = crc_next(crc_acc, b);
        position = p + 1;
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        awaited.push_back(r);
        return;
      end
      k = (p - HdrBytes - len) & 3;
      trailer_acc = trailer_acc | (32'(b) << (8 * k));
      position = p + 1;
      if (k == 3) begin
        if (trailer_acc != (crc_acc ^ CRC_INIT)) fail(ST_PAYLOAD_CRC, 1'b1);
        else begin
          push_report(ST_OK, 1'b1);
          restart();
        end
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(deframe_result_t got);
      deframe_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %0h",
                 $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      compare_field("kind", 64'(want.kind), 64'(got.kind));
      compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("msg_type", 64'(want.msg_type), 64'(got.msg_type));
      compare_field("frame_flags", 64'(want.frame_flags), 64'(got.frame_flags));
      compare_field("session_word", want.session_word, got.session_word);
      compare_field("epoch_word", want.epoch_word, got.epoch_word);
      compare_field("boot_word", want.boot_word, got.boot_word);
      compare_field("sequence_word", want.sequence_word, got.sequence_word);
      compare_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        feed_valid = 1'b0;
  logic        feed_stall;
  logic        cmd = CMD_BYTE;
  logic [7:0]  byte_value = 8'h00;

  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_PAYLOAD_CAP;
  logic [16:0] cfg_data = '0;

  logic        res_valid;
  logic        res_stall = 1'b0;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [15:0] msg_type;
  logic [31:0] frame_flags;
  logic [63:0] session_word;
  logic [63:0] epoch_word;
  logic [63:0] boot_word;
  logic [63:0] sequence_word;
  logic [16:0] payload_length;
  logic        last;

  deframe_predictor pred;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_fed = 0;

  crc_checked_stream_deframer dut (
    .clk(clk),
    .rst(rst),
    .feed_valid(feed_valid),
    .feed_stall(feed_stall),
    .cmd(cmd),
    .byte_value(byte_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .kind(kind),
    .payload_byte(payload_byte),
    .status(status),
    .msg_type(msg_type),
    .frame_flags(frame_flags),
    .session_word(session_word),
    .epoch_word(epoch_word),
    .boot_word(boot_word),
    .sequence_word(sequence_word),
    .payload_length(payload_length),
    .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    deframe_result_t seen;
    if (!rst && res_valid && !res_stall) begin
      seen.kind = kind;
      seen.payload_byte = payload_byte;
      seen.status = status;
      seen.msg_type = msg_type;
      seen.frame_flags = frame_flags;
      seen.session_word = session_word;
      seen.epoch_word = epoch_word;
      seen.boot_word = boot_word;
      seen.sequence_word = sequence_word;
      seen.payload_length = payload_length;
      seen.last = last;
      pred.check_result(seen);
    end
  end

  // Leaves feed_valid high after acceptance; the caller's next action in the
  // same step either presents the next item or lowers it.
  task automatic send_item(input logic c, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      feed_valid <= 1'b0;
      @(posedge clk);
    end
    feed_valid <= 1'b1;
    cmd <= c;
    byte_value <= b;
    do @(posedge clk); while (feed_stall);
    pred.predict_item(c, b);
    if (c == CMD_BYTE) bytes_fed++;
  endtask

  task automatic settle();
    feed_valid <= 1'b0;
    while (pred.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [16:0] max_pay, input logic [16:0] ver,
                              input logic [16:0] lo, input logic [16:0] hi);
    logic [1:0]  idx [4];
    logic [16:0] val [4];
    idx = '{CFG_PAYLOAD_CAP, CFG_EXPECTED_VERSION, CFG_LOWEST_TYPE, CFG_HIGHEST_TYPE};
    val = '{max_pay, ver, lo, hi};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      pred.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [15:0] ver, input logic [15:0] typ,
                            input logic [31:0] len_field, input int n_pay,
                            input frame_flaw_t flaw);
    logic [7:0]  hdr [HdrBytes];
    logic [31:0] crc;
    logic [31:0] tail;
    logic [7:0]  b;
    int total;
    int cut_at;
    hdr[0] = MAGIC_0;
    hdr[1] = MAGIC_1;
    hdr[2] = MAGIC_2;
    hdr[3] = MAGIC_3;
    for (int i = 4; i < HdrBytes; i++) hdr[i] = 8'($urandom);
    for (int k = 0; k < 2; k++) begin
      hdr[4 + k] = ver[8*k +: 8];
      hdr[6 + k] = typ[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) hdr[44 + k] = len_field[8*k +: 8];
    crc = CRC_INIT;
    for (int i = 0; i < HdrCrcSpan; i++) crc = pred.crc_next(crc, hdr[i]);
    crc = ~crc;
    for (int k = 0; k < 4; k++) hdr[HdrCrcSpan + k] = crc[8*k +: 8];
    if (flaw == FLAW_MAGIC) hdr[$urandom_range(3)] ^= 8'($urandom_range(255, 1));
    if (flaw == FLAW_HDR_CRC)
      hdr[HdrCrcSpan + $urandom_range(3)] ^= 8'($urandom_range(255, 1));
    total = HdrBytes + n_pay + 4;
    cut_at = (flaw == FLAW_CUT) ? $urandom_range(total - 1) : total;
    crc = CRC_INIT;
    tail = '0;
    for (int i = 0; i < total && i < cut_at; i++) begin
      if (i < HdrBytes) begin
        b = hdr[i];
      end else if (i < HdrBytes + n_pay) begin
        b = 8'($urandom);
        crc = pred.crc_next(crc, b);
      end else begin
        if (i == HdrBytes + n_pay) begin
          tail = ~crc;
          if (flaw == FLAW_TRAILER)
            tail ^= 32'($urandom_range(255, 1)) << (8 * $urandom_range(3));
        end
        b = tail[8*(i - HdrBytes - n_pay) +: 8];
      end
      send_item(CMD_BYTE, b);
    end
    // Bytes after an error are ignored; a clear command restarts parsing.
    if (flaw == FLAW_CUT || pred.halted) send_item(CMD_CLEAR, 8'($urandom));
  endtask

  task automatic random_frame();
    int unsigned lim;
    int n;
    int pick;
    logic [15:0] ver;
    logic [15:0] typ;
    logic [31:0] len_field;
    frame_flaw_t flaw;
    lim = ($urandom_range(7) == 0) ? 64 : 16;
    if (lim > pred.bound()) lim = pred.bound();
    n = $urandom_range(lim, 0);
    ver = pred.version_reg;
    typ = 16'($urandom_range(pred.type_hi_reg, pred.type_lo_reg));
    len_field = 32'(n);
    flaw = FLAW_NONE;
    pick = $urandom_range(99);
    if (pick < 70) flaw = FLAW_NONE;
    else if (pick < 74) flaw = FLAW_MAGIC;
    else if (pick < 78) flaw = FLAW_HDR_CRC;
    else if (pick < 82) ver ^= 16'(1) << $urandom_range(15);
    else if (pick < 86) begin
      if (pred.type_lo_reg > 0) typ = 16'($urandom_range(pred.type_lo_reg - 1, 0));
      else if (pred.type_hi_reg < 16'hFFFF)
        typ = 16'($urandom_range(16'hFFFF, pred.type_hi_reg + 1));
      else ver ^= 16'(1) << $urandom_range(15);
    end else if (pick < 90) begin
      if ($urandom_range(1) == 0) len_field = pred.bound() + $urandom_range(3, 1);
      else len_field = $urandom | 32'h0002_0000;
    end else if (pick < 94) flaw = FLAW_TRAILER;
    else if (pick < 97) flaw = FLAW_CUT;
    else begin
      // Line noise followed by a resync.
      repeat ($urandom_range(12, 1)) send_item(CMD_BYTE, 8'($urandom));
      send_item(CMD_CLEAR, 8'($urandom));
      return;
    end
    send_frame(ver, typ, len_field, n, flaw);
  endtask

  task automatic feed_random(input int n);
    int target;
    target = bytes_fed + n;
    while (bytes_fed < target) random_frame();
  endtask

  initial begin
    pred = new();
    send_idle_pct = 33;
    recv_stall_pct = 66;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset configuration.
    send_item(CMD_CLEAR, 8'hFF);
    send_frame(16'd1, 16'd1, 32'd0, 0, FLAW_NONE);
    send_frame(16'd1, 16'd16, 32'd3, 3, FLAW_NONE);
    send_frame(16'd1, 16'd5, 32'd2, 2, FLAW_MAGIC);
    send_frame(16'd1, 16'd5, 32'd4, 4, FLAW_HDR_CRC);
    send_frame(16'hFFFF, 16'd5, 32'd1, 1, FLAW_NONE);
    send_frame(16'd1, 16'd0, 32'd1, 1, FLAW_NONE);
    send_frame(16'd1, 16'd17, 32'd1, 1, FLAW_NONE);
    send_frame(16'd1, 16'd3, 32'h0001_0001, 2, FLAW_NONE);
    send_frame(16'd2, 16'd3, 32'hFFFF_FFFF, 2, FLAW_NONE);
    send_frame(16'd1, 16'd8, 32'd5, 5, FLAW_TRAILER);
    send_frame(16'd1, 16'd8, 32'd6, 6, FLAW_CUT);
    feed_random(120);
    settle();

    // Zero payload bound; bit 16 of the 16-bit registers must be dropped.
    send_idle_pct = 66;
    recv_stall_pct = 33;
    program_regs(17'h0_0000, 17'h1_0000, 17'h1_0000, 17'h1_FFFF);
    send_frame(16'h0000, 16'h0000, 32'd0, 0, FLAW_NONE);
    send_frame(16'h0000, 16'hFFFF, 32'd1, 1, FLAW_NONE);
    settle();
    // An empty type range rejects every frame.
    program_regs(17'd0, 17'd0, 17'd9, 17'd8);
    send_frame(16'h0000, 16'd8, 32'd0, 0, FLAW_NONE);
    settle();
    program_regs(17'd40, 17'd0, 17'h0100, 17'h01FF);
    feed_random(120);
    settle();

    // Register above the hard maximum is clamped; a length at the bound is
    // accepted and its first payload bytes stream out before a resync.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    program_regs(17'h1_FFFF, 17'hFFFF, 17'hFFFF, 17'hFFFF);
    send_frame(16'hFFFF, 16'hFFFF, 32'h0001_0001, 1, FLAW_NONE);
    send_frame(16'hFFFF, 16'hFFFF, 32'h0001_0000, 12, FLAW_NONE);
    send_item(CMD_CLEAR, 8'h00);
    settle();
    program_regs(17'h0_FFFF, 17'hFFFF, 17'hFFFF, 17'hFFFF);
    send_frame(16'hFFFF, 16'hFFFF, 32'h0001_0000, 1, FLAW_NONE);
    settle();
    program_regs(17'd24, 17'hA5C3, 17'd0, 17'h7FFF);
    feed_random(120);
    settle();

    if (pred.errors == 0 && pred.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
